### src/mpu_pkg.sv
// Package for the palettized Z-order texture unswizzler.
// Holds the channel payload types, geometry type and shared constants.
// No dependencies.
package mpu_pkg;

  localparam int MAX_SIDE_LOG2_DEF   = 10;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MIN_SIDE_LOG2       = 3;

  localparam int SIDE_W   = 4;
  localparam int SLOT_W   = 8;
  localparam int RGBA_W   = 32;
  localparam int ADDR_W   = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] entry_slot;
    logic [RGBA_W-1:0] entry_rgba;
    logic [SLOT_W-1:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [RGBA_W-1:0] colour;
    logic              last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] wl;
    logic [SIDE_W-1:0] hl;
  } geom_t;

endpackage

### src/mpu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the palette store.
module mpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds its value until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/mpu_addr_gen.sv
// Pixel counter and Z-order to linear address translation.
// Depends on mpu_pkg for the geometry type and address width.
module mpu_addr_gen
  import mpu_pkg::*;
#(
  parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  geom_t             geom,
  input  logic              step,
  output logic [ADDR_W-1:0] dest_address,
  output logic              last_pixel
);

  localparam int CNT_W = 2 * MAX_SIDE_LOG2;

  logic [CNT_W-1:0]         counter;
  logic [CNT_W-1:0]         counter_next;
  logic [CNT_W:0]           total_full;
  logic [CNT_W-1:0]         total_mask;
  logic [CNT_W:0]           inner_full;
  logic [CNT_W-1:0]         inner_mask;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         inner;
  logic [CNT_W-1:0]         blk;
  logic [SIDE_W-1:0]        bl;
  logic                     wide;
  logic [MAX_SIDE_LOG2-1:0] xg;
  logic [MAX_SIDE_LOG2-1:0] yg;
  logic [CNT_W-1:0]         x_full;
  logic [CNT_W-1:0]         y_full;
  logic [CNT_W-1:0]         addr_full;
  logic [CNT_W+ADDR_W-1:0]  addr_ext;

  assign wide = geom.wl > geom.hl;
  assign bl   = wide ? geom.hl : geom.wl;

  assign total_full = ((CNT_W+1)'(1) << ({1'b0, geom.wl} + {1'b0, geom.hl})) - (CNT_W+1)'(1);
  assign total_mask = total_full[CNT_W-1:0];
  assign inner_full = ((CNT_W+1)'(1) << {bl, 1'b0}) - (CNT_W+1)'(1);
  assign inner_mask = inner_full[CNT_W-1:0];

  // The counter is rewrapped to the current image size before use.
  assign cnt   = counter & total_mask;
  assign inner = cnt & inner_mask;
  assign blk   = cnt >> {bl, 1'b0};

  always_comb begin
    for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
      xg[i] = (i < int'(bl)) ? inner[2*i] : 1'b0;
      yg[i] = (i < int'(bl)) ? inner[2*i+1] : 1'b0;
    end
  end

  // Blocks tile along the longer axis; the in-block part stays below 2^bl,
  // so the block offset combines by OR.
  assign x_full    = CNT_W'(xg) | (wide ? (blk << bl) : '0);
  assign y_full    = CNT_W'(yg) | (wide ? '0 : (blk << bl));
  assign addr_full = (y_full << geom.wl) | x_full;
  assign addr_ext  = {{ADDR_W{1'b0}}, addr_full};

  assign dest_address = addr_ext[ADDR_W-1:0];
  assign last_pixel   = cnt == total_mask;
  assign counter_next = last_pixel ? '0 : cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else if (step) begin
      counter <= counter_next;
    end
  end

endmodule

### src/morton_palette_unswizzle.sv
// Top level of the palettized Z-order texture unswizzler.
// Depends on mpu_pkg, mpu_ram and mpu_addr_gen.

// Takes one input transfer per clock cycle unless the output stalls. A load item
// writes one palette slot and yields nothing. A pixel item reads the palette
// RAM (one read port, registered read data) while the address path converts the
// running counter. Its result is registered in the middle stage and then in the
// output register, where it is held until taken. The input
// stalls only while a result is held on the output and the middle stage is
// full. Geometry registers are clamped to the supported side range when
// written and must only change while the block is idle. The palette RAM has
// no reset and needs no clearing pass; entries must be loaded before use.
module morton_palette_unswizzle
  import mpu_pkg::*;
#(
  parameter int MAX_SIDE_LOG2   = MAX_SIDE_LOG2_DEF,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  logic [SIDE_W-1:0] width_log2;
  logic [SIDE_W-1:0] height_log2;
  logic [SIDE_W-1:0] cfg_clamped;
  geom_t             geom;

  logic              in_fire;
  logic              pixel_fire;
  logic              load_ok;
  logic              index_ok;
  logic [ADDR_W-1:0] gen_address;
  logic              gen_last;
  logic [RGBA_W-1:0] pal_rdata;

  logic              s1_valid;
  logic              s1_adv;
  logic [ADDR_W-1:0] s1_address;
  logic              s1_last;
  logic              s1_index_ok;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data < SIDE_W'(MIN_SIDE_LOG2)) begin
      cfg_clamped = SIDE_W'(MIN_SIDE_LOG2);
    end else if (cfg_data > SIDE_W'(MAX_SIDE_LOG2)) begin
      cfg_clamped = SIDE_W'(MAX_SIDE_LOG2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2  <= SIDE_W'(MIN_SIDE_LOG2);
      height_log2 <= SIDE_W'(MIN_SIDE_LOG2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_LOG2: begin
          width_log2 <= cfg_clamped;
        end
        CFG_HEIGHT_LOG2: begin
          height_log2 <= cfg_clamped;
        end
        default: begin
        end
      endcase
    end
  end

  assign geom.wl = width_log2;
  assign geom.hl = height_log2;

  // The output register frees the middle stage whenever it is empty or taken.
  assign s1_adv     = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_adv;
  assign in_fire    = in_valid && in_ready;
  assign pixel_fire = in_fire && (in_data.cmd == CMD_PIXEL);
  assign load_ok    = {1'b0, in_data.entry_slot} < (SLOT_W+1)'(PALETTE_ENTRIES);
  assign index_ok   = {1'b0, in_data.pixel_index} < (SLOT_W+1)'(PALETTE_ENTRIES);

  mpu_ram #(
    .WIDTH(RGBA_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (in_fire && (in_data.cmd == CMD_LOAD) && load_ok),
    .waddr(in_data.entry_slot[PAL_AW-1:0]),
    .wdata(in_data.entry_rgba),
    .re   (pixel_fire),
    .raddr(in_data.pixel_index[PAL_AW-1:0]),
    .rdata(pal_rdata)
  );

  mpu_addr_gen #(
    .MAX_SIDE_LOG2(MAX_SIDE_LOG2)
  ) u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .step        (pixel_fire),
    .dest_address(gen_address),
    .last_pixel  (gen_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= pixel_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      s1_address  <= gen_address;
      s1_last     <= gen_last;
      s1_index_ok <= index_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  // Palette read data is held in the RAM until the next pixel transfer.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_data.dest_address <= s1_address;
      out_data.colour       <= s1_index_ok ? pal_rdata : '0;
      out_data.last_pixel   <= s1_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_ready)
    else $error("middle stage overwritten while stalled");

  a_pixel_enters: assert property (@(posedge clk) disable iff (rst)
    pixel_fire |=> s1_valid)
    else $error("pixel transfer lost before the middle stage");

  a_width_clamp: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == CFG_WIDTH_LOG2) && (cfg_data > SIDE_W'(MAX_SIDE_LOG2)))
    |=> (width_log2 == SIDE_W'(MAX_SIDE_LOG2)))
    else $error("width register not clamped");
`endif

endmodule

### tb/morton_palette_unswizzle_test.sv
// Self-checking testbench for morton_palette_unswizzle: palette loads and Z-order
// pixel transfers are checked against an in-bench model of the address and colour path.
// Depends on mpu_pkg and the morton_palette_unswizzle RTL.
`timescale 1ns / 1ps

module morton_palette_unswizzle_test;
  import mpu_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIDE_W-1:0]    cfg_data = '0;

  morton_palette_unswizzle u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores.
  in_item_t  stim_items[$];
  out_item_t expected_texels[$];

  // Model state: palette copy, pixel counter and clamped geometry.
  logic [RGBA_W-1:0] palette_mirror [PALETTE_ENTRIES_DEF];
  logic [31:0]       pix_count = '0;
  int                geo_wl = MIN_SIDE_LOG2;
  int                geo_hl = MIN_SIDE_LOG2;

  int   items_queued = 0;
  int   items_taken = 0;
  int   err_count = 0;
  int   results_checked = 0;
  int   wraps_seen = 0;
  int   loads_seen = 0;
  int   geometries = 1;
  int   idle_pct = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   stall_cycles = 0;
  logic in_fire = 1'b0;

  function automatic int clamp_side(input logic [SIDE_W-1:0] v);
    int s;
    s = int'(v);
    if (s < MIN_SIDE_LOG2) s = MIN_SIDE_LOG2;
    if (s > MAX_SIDE_LOG2_DEF) s = MAX_SIDE_LOG2_DEF;
    return s;
  endfunction

  // Computes the result of one pixel transfer and advances the pixel counter.
  function automatic out_item_t unswizzle_pixel(input logic [SLOT_W-1:0] idx);
    int          bl;
    logic [31:0] total_mask;
    logic [31:0] cnt;
    logic [31:0] inner;
    logic [31:0] blk;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] lin;
    out_item_t   r;
    bl = (geo_wl <= geo_hl) ? geo_wl : geo_hl;
    total_mask = (32'd1 << (geo_wl + geo_hl)) - 32'd1;
    cnt = pix_count & total_mask;
    inner = cnt & ((32'd1 << (2 * bl)) - 32'd1);
    blk = cnt >> (2 * bl);
    x = '0;
    y = '0;
    // Even counter bits form x and odd bits form y inside one square block.
    for (int i = 0; i < bl; i++) begin
      x[i] = inner[2 * i];
      y[i] = inner[2 * i + 1];
    end
    if (geo_wl <= geo_hl) y = y + (blk << bl);
    else x = x + (blk << bl);
    lin = (y << geo_wl) + x;
    r.dest_address = lin[ADDR_W-1:0];
    r.colour = (idx < PALETTE_ENTRIES_DEF) ? palette_mirror[idx] : '0;
    r.last_pixel = (cnt == total_mask);
    pix_count = r.last_pixel ? 32'd0 : cnt + 32'd1;
    return r;
  endfunction

  function automatic in_item_t make_load(input logic [SLOT_W-1:0] slot,
                                         input logic [RGBA_W-1:0] rgba);
    in_item_t it;
    it.cmd = CMD_LOAD;
    it.entry_slot = slot;
    it.entry_rgba = rgba;
    it.pixel_index = SLOT_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_pixel(input logic [SLOT_W-1:0] idx);
    in_item_t it;
    it.cmd = CMD_PIXEL;
    it.entry_slot = SLOT_W'($urandom);
    it.entry_rgba = $urandom;
    it.pixel_index = idx;
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_item(input in_item_t it);
    stim_items.push_back(it);
    items_queued++;
  endtask

  // Returns at a falling edge once every transfer is taken and every result has come.
  task automatic wait_idle();
    @(negedge clk);
    while (items_taken != items_queued || expected_texels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_geometry(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH_LOG2;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= CFG_HEIGHT_LOG2;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    geometries++;
  endtask

  task automatic run_phase(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                           input int n, input int idle);
    set_geometry(w, h);
    idle_pct = idle;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 20) push_item(make_load(SLOT_W'($urandom), $urandom));
      else push_item(make_pixel(SLOT_W'($urandom)));
    end
    wait_idle();
  endtask

  // Input driver: holds each item until its transfer, with random idle bursts.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (stim_items.size() == 0) begin
      in_valid <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      in_gap = $urandom_range(1, 6) - 1;
    end else begin
      in_data <= stim_items.pop_front();
      in_valid <= 1'b1;
    end
  end

  // Output backpressure.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_ready <= 1'b0;
      out_gap = $urandom_range(1, 6) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: mirrors configuration writes, predicts on input transfers and
  // checks every output transfer against the oldest expectation.
  always @(posedge clk) begin : texel_monitor
    out_item_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH_LOG2:  geo_wl = clamp_side(cfg_data);
          CFG_HEIGHT_LOG2: geo_hl = clamp_side(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        items_taken++;
        if (in_data.cmd == CMD_PIXEL) begin
          expected_texels.push_back(unswizzle_pixel(in_data.pixel_index));
        end else begin
          if (in_data.entry_slot < PALETTE_ENTRIES_DEF)
            palette_mirror[in_data.entry_slot] = in_data.entry_rgba;
          loads_seen++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_texels.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, address %h",
                                    out_data.dest_address));
        end else begin
          want = expected_texels.pop_front();
          if (out_data.dest_address !== want.dest_address)
            report_mismatch($sformatf("dest_address got %h want %h",
                                      out_data.dest_address, want.dest_address));
          if (out_data.colour !== want.colour)
            report_mismatch($sformatf("colour got %h want %h at address %h",
                                      out_data.colour, want.colour, want.dest_address));
          if (out_data.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last_pixel got %b want %b at address %h",
                                      out_data.last_pixel, want.last_pixel,
                                      want.dest_address));
          results_checked++;
          if (want.last_pixel) wraps_seen++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("morton_palette_unswizzle regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset geometry: extreme slots and colours, read right
    // after write, and all-ones filler fields on both kinds of transfer.
    idle_pct = 25;
    push_item(make_load(8'h00, 32'h0000_0000));
    push_item(make_load(8'hFF, 32'hFFFF_FFFF));
    push_item(make_load(8'h55, 32'h0000_00FF));
    push_item(make_load(8'hAA, 32'hFF00_0000));
    push_item(make_pixel(8'h00));
    push_item(make_pixel(8'hFF));
    push_item(make_pixel(8'h55));
    push_item(make_pixel(8'hAA));
    push_item(make_load(8'h00, 32'h1234_5678));
    push_item(make_pixel(8'h00));
    push_item(in_item_t'{cmd: CMD_PIXEL, entry_slot: 8'hFF, entry_rgba: 32'hFFFF_FFFF,
                         pixel_index: 8'h00});
    push_item(in_item_t'{cmd: CMD_LOAD, entry_slot: 8'h55, entry_rgba: 32'hA5A5_5A5A,
                         pixel_index: 8'hFF});
    push_item(make_pixel(8'h55));
    wait_idle();

    // Fill the whole palette so that random pixels never read an unwritten slot.
    idle_pct = 20;
    for (int s = 0; s < PALETTE_ENTRIES_DEF; s++) push_item(make_load(SLOT_W'(s), $urandom));
    wait_idle();

    // Geometry phases; the counter carries over, so each change lands mid-image.
    // Out-of-range register values check the clamp at both ends.
    run_phase(4'd3,  4'd3,  120, 20);
    run_phase(4'd4,  4'd3,  100, 0);
    run_phase(4'd3,  4'd4,  100, 30);
    run_phase(4'd15, 4'd15, 30,  20);
    run_phase(4'd0,  4'd1,  60,  10);
    run_phase(4'd10, 4'd3,  30,  20);
    run_phase(4'd3,  4'd10, 30,  20);
    run_phase(4'd5,  4'd4,  50,  20);
    run_phase(4'd2,  4'd11, 30,  0);
    run_phase(4'd3,  4'd3,  35,  0);

    repeat (6) @(negedge clk);
    if (expected_texels.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_texels.size()));
    $display("Covered %0d palette loads and %0d pixel results, %0d of them image wraps,",
             loads_seen, results_checked, wraps_seen);
    $display("across %0d geometry settings including clamped register values.", geometries);
    if (err_count == 0) begin
      $display("morton_palette_unswizzle regression: pass");
    end else begin
      $display("morton_palette_unswizzle regression: fail");
    end
    $finish;
  end

endmodule

### morton_palette_unswizzle.f
src/mpu_pkg.sv
src/mpu_ram.sv
src/mpu_addr_gen.sv
src/morton_palette_unswizzle.sv
tb/morton_palette_unswizzle_test.sv
